FILE: src/quota_fifo_with_budget_drain_defines.svh
// Assertion macros used by the top-level RTL file of the print queue.
`ifndef QUOTA_FIFO_WITH_BUDGET_DRAIN_DEFINES_SVH
`define QUOTA_FIFO_WITH_BUDGET_DRAIN_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define QFBD_ASSERT_IMPL(name, clk_i, rst_n_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define QFBD_ASSERT_NEXT(name, clk_i, rst_n_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QFBD_ASSERT_IMPL(name, clk_i, rst_n_i, ante, cons)
`define QFBD_ASSERT_NEXT(name, clk_i, rst_n_i, ante, cons)
`endif

`endif

FILE: src/qfbd_pkg.sv
package qfbd_pkg;

	// Field widths of one job word and of the budget and count result fields.
	localparam int DOC_W   = 16;
	localparam int OWNER_W = 8;
	localparam int PAGES_W = 12;
	localparam int BUD_W   = 16;
	localparam int CNT_W   = 5;
	localparam int JOB_W   = DOC_W + OWNER_W + PAGES_W;

	// Width of the shared compare and subtract unit.
	localparam int CMP_W = 16;

	localparam logic [CNT_W-1:0] QUOTA_RESET = 5'd3;
	localparam logic [CNT_W-1:0] CNT_MAX     = 5'd31;
	localparam logic [CNT_W-1:0] DRAIN_POPS  = 5'd16;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_QUOTA_REJ = 3'd1,
		ST_FULL_REJ  = 3'd2,
		ST_PRINTED   = 3'd3,
		ST_ALL_DONE  = 3'd4,
		ST_STOPPED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [DOC_W-1:0]   doc;
		logic [OWNER_W-1:0] owner;
		logic [PAGES_W-1:0] pages;
	} job_t;

	typedef struct packed {
		status_t            status;
		logic [DOC_W-1:0]   doc;
		logic [OWNER_W-1:0] owner;
		logic [PAGES_W-1:0] pages;
		logic [BUD_W-1:0]   left;
		logic [CNT_W-1:0]   cnt;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
	} cmp_req_t;

	typedef struct packed {
		logic             eq;
		logic             lt;
		logic [CMP_W-1:0] diff;
	} cmp_rsp_t;

endpackage

FILE: src/qfbd_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module qfbd_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/qfbd_cmp.sv
// Shared compare and subtract unit: equality, less-than and difference.
module qfbd_cmp import qfbd_pkg::*; (
	input  cmp_req_t req,
	output cmp_rsp_t rsp
);

	logic [CMP_W:0] diff_wide;

	// A borrow out of the subtraction means a is below b.
	assign diff_wide = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.lt    = diff_wide[CMP_W];
	assign rsp.diff  = diff_wide[CMP_W-1:0];
	assign rsp.eq    = (req.a == req.b);

endmodule

FILE: src/quota_fifo_with_budget_drain.sv
// Print-job queue with a per-owner admission quota and a paper-budget drain.
// Jobs sit in a circular RAM of QUEUE_DEPTH words; a sequencer drives one
// compare and subtract unit and the single RAM read port. For a submit word
// the queue is walked one entry per cycle to count the owner's jobs, the last
// read is counted once its registered data returns, then the quota and full
// checks run and the job is appended if it passes both. A drain word takes
// two steps per printed job (RAM read, then compare and subtract of the
// budget); at most sixteen jobs are printed per drain. in_ready is high only
// while no word is in work. Each result word waits in an output register, and
// the sequencer stalls while that register is full and not taken.
// max_jobs_per_owner (quota_q) is written through cfg_we and cfg_wdata and
// resets to 3; the user must write it only while the block is idle, since the
// block itself does not enforce this.
`include "quota_fifo_with_budget_drain_defines.svh"
module quota_fifo_with_budget_drain import qfbd_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [DOC_W-1:0]   doc_id,
	input  logic [OWNER_W-1:0] owner_id,
	input  logic [PAGES_W-1:0] page_count,
	input  logic [BUD_W-1:0]   paper_budget,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [DOC_W-1:0]   out_doc,
	output logic [OWNER_W-1:0] out_owner,
	output logic [PAGES_W-1:0] out_pages,
	output logic [BUD_W-1:0]   paper_left,
	output logic [CNT_W-1:0]   owner_count,
	output logic               last
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_SCAN     = 5'b00010,
		S_DECIDE   = 5'b00100,
		S_DRN_RD   = 5'b01000,
		S_DRN_EVAL = 5'b10000
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [OCC_W-1:0]   occ_q;
	logic [CNT_W-1:0]   quota_q;
	logic [DOC_W-1:0]   doc_q;
	logic [OWNER_W-1:0] own_q;
	logic [PAGES_W-1:0] pg_q;
	logic [BUD_W-1:0]   bud_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [OCC_W-1:0]   iss_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic               rd_vld_s1;
	logic [CNT_W-1:0]   pops_q;
	logic               out_valid_q;
	result_t            res_q;

	logic               out_free;
	logic               out_load;
	logic               scan_issue;
	logic               ram_rd_en;
	logic [PTR_W-1:0]   ram_raddr;
	logic               ram_we;
	logic [JOB_W-1:0]   ram_rdata;
	job_t               rd_job;
	job_t               wr_job;
	cmp_req_t           cmp_req;
	cmp_rsp_t           cmp_rsp;
	logic               quota_rej;
	logic               queue_full;
	logic               drn_stop;
	logic               emit_print;
	status_t            submit_st;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Job storage.
	assign wr_job = '{doc: doc_q, owner: own_q, pages: pg_q};
	assign rd_job = job_t'(ram_rdata);

	qfbd_ram #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(JOB_W'(wr_job)),
		.rd_en(ram_rd_en),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Operand selection for the shared unit, by sequencer state.
	always_comb begin
		unique case (state_q)
			S_SCAN: begin
				cmp_req.a = CMP_W'(own_q);
				cmp_req.b = CMP_W'(rd_job.owner);
			end
			S_DECIDE: begin
				cmp_req.a = CMP_W'(cnt_q);
				cmp_req.b = CMP_W'(quota_q);
			end
			default: begin
				cmp_req.a = CMP_W'(bud_q);
				cmp_req.b = CMP_W'(rd_job.pages);
			end
		endcase
	end

	qfbd_cmp u_cmp (
		.req(cmp_req),
		.rsp(cmp_rsp)
	);

	// Handshake and control decodes.
	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign scan_issue = (state_q == S_SCAN) && (iss_q < occ_q);
	assign ram_rd_en  = scan_issue || ((state_q == S_DRN_RD) && (occ_q != '0));
	assign ram_raddr  = (state_q == S_SCAN) ? rd_ptr_q : head_q;
	assign quota_rej  = !cmp_rsp.lt;
	assign queue_full = (occ_q == OCC_FULL);
	assign ram_we     = (state_q == S_DECIDE) && out_free && !quota_rej && !queue_full;
	assign drn_stop   = (pops_q == DRAIN_POPS) || cmp_rsp.lt;
	assign emit_print = (state_q == S_DRN_EVAL) && out_free && !drn_stop;

	// A result word enters the output register whenever a step that makes one completes.
	assign out_load = out_free && ((state_q == S_DECIDE) || (state_q == S_DRN_EVAL)
		|| ((state_q == S_DRN_RD) && (occ_q == '0)));

	always_comb begin
		if (quota_rej) begin
			submit_st = ST_QUOTA_REJ;
		end else if (queue_full) begin
			submit_st = ST_FULL_REJ;
		end else begin
			submit_st = ST_ACCEPTED;
		end
	end

	// Sequencer, queue pointers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			quota_q     <= QUOTA_RESET;
			cnt_q       <= '0;
			iss_q       <= '0;
			rd_ptr_q    <= '0;
			rd_vld_s1   <= 1'b0;
			pops_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				quota_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						doc_q     <= doc_id;
						own_q     <= owner_id;
						pg_q      <= page_count;
						bud_q     <= paper_budget;
						cnt_q     <= '0;
						iss_q     <= '0;
						rd_ptr_q  <= head_q;
						rd_vld_s1 <= 1'b0;
						pops_q    <= '0;
						state_q   <= req_type ? S_DRN_RD : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= scan_issue;
					if (scan_issue) begin
						rd_ptr_q <= next_ptr(rd_ptr_q);
						iss_q    <= iss_q + 1'b1;
					end
					if (rd_vld_s1 && cmp_rsp.eq && (cnt_q != CNT_MAX)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (!scan_issue && !rd_vld_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						res_q       <= '{status: submit_st, doc: doc_q, owner: own_q,
							pages: pg_q, left: '0, cnt: cnt_q, last: 1'b1};
						if (ram_we) begin
							tail_q <= next_ptr(tail_q);
							occ_q  <= occ_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_DRN_RD: begin
					if (occ_q != '0) begin
						state_q <= S_DRN_EVAL;
					end else if (out_free) begin
						res_q       <= '{status: ST_ALL_DONE, doc: '0, owner: '0,
							pages: '0, left: bud_q, cnt: '0, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_DRN_EVAL: begin
					if (out_free) begin
						if (drn_stop) begin
							res_q   <= '{status: ST_STOPPED, doc: rd_job.doc,
								owner: rd_job.owner, pages: rd_job.pages, left: bud_q,
								cnt: '0, last: 1'b1};
							state_q <= S_IDLE;
						end else begin
							res_q   <= '{status: ST_PRINTED, doc: rd_job.doc,
								owner: rd_job.owner, pages: rd_job.pages,
								left: cmp_rsp.diff, cnt: '0, last: 1'b0};
							bud_q   <= cmp_rsp.diff;
							head_q  <= next_ptr(head_q);
							occ_q   <= occ_q - 1'b1;
							pops_q  <= pops_q + 1'b1;
							state_q <= S_DRN_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result ports.
	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign out_doc     = res_q.doc;
	assign out_owner   = res_q.owner;
	assign out_pages   = res_q.pages;
	assign paper_left  = res_q.left;
	assign owner_count = res_q.cnt;
	assign last        = res_q.last;

	// The queue never holds more jobs than it has slots.
	`QFBD_ASSERT_IMPL(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OCC_FULL)
	// A job is written only into a queue with a free slot.
	`QFBD_ASSERT_IMPL(a_write_room, clk, arst_n, ram_we, occ_q < OCC_FULL)
	// A drain never prints more than its pop limit.
	`QFBD_ASSERT_IMPL(a_pop_limit, clk, arst_n, 1'b1, pops_q <= DRAIN_POPS)
	// Each printed job leaves the queue one entry shorter.
	`QFBD_ASSERT_NEXT(a_print_pop, clk, arst_n, emit_print, occ_q == $past(occ_q) - 1'b1)

endmodule

FILE: tb/tb_quota_fifo_with_budget_drain.sv
`timescale 1ns / 1ps

module tb_quota_fifo_with_budget_drain import qfbd_pkg::*;;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 50;

	// Request codes of the req_type field.
	localparam bit REQ_SUBMIT = 1'b0;
	localparam bit REQ_DRAIN  = 1'b1;

	// One line of the directed script. A row may first change the quota, may be
	// repeated with the document id counting up, and may carry a typed result.
	typedef struct packed {
		bit                 set_q;
		logic [CNT_W-1:0]   quota;
		bit                 req;
		logic [DOC_W-1:0]   doc;
		logic [OWNER_W-1:0] owner;
		logic [PAGES_W-1:0] pages;
		logic [BUD_W-1:0]   budget;
		logic [7:0]         reps;
		bit                 fixed;
		status_t            fst;
		logic [CNT_W-1:0]   fcnt;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = 1'b0;
	logic [DOC_W-1:0]   doc_id = '0;
	logic [OWNER_W-1:0] owner_id = '0;
	logic [PAGES_W-1:0] page_count = '0;
	logic [BUD_W-1:0]   paper_budget = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic [DOC_W-1:0]   out_doc;
	logic [OWNER_W-1:0] out_owner;
	logic [PAGES_W-1:0] out_pages;
	logic [BUD_W-1:0]   paper_left;
	logic [CNT_W-1:0]   owner_count;
	logic               last;

	// Shadow copy of the print queue and the quota register.
	logic [DOC_W-1:0]   q_doc [DEPTH];
	logic [OWNER_W-1:0] q_owner [DEPTH];
	logic [PAGES_W-1:0] q_pages [DEPTH];
	int                 q_head = 0;
	int                 q_tail = 0;
	int                 q_fill = 0;
	logic [CNT_W-1:0]   q_quota = QUOTA_RESET;

	result_t   awaited_results[$];
	stim_row_t script[$];

	int sender_idle_pct = 24;
	int recv_idle_pct = 51;
	bit long_hold = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int mismatches = 0;
	int n_words = 0;
	int n_results = 0;
	int n_printed = 0;
	int n_quota_rej = 0;
	int n_full_rej = 0;

	quota_fifo_with_budget_drain #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.doc_id(doc_id),
		.owner_id(owner_id),
		.page_count(page_count),
		.paper_budget(paper_budget),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_doc(out_doc),
		.out_owner(out_owner),
		.out_pages(out_pages),
		.paper_left(paper_left),
		.owner_count(owner_count),
		.last(last)
	);

	// Free-running clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_quota_fifo_with_budget_drain: errors");
			$finish;
		end
	end

	function automatic stim_row_t row(bit set_q, logic [CNT_W-1:0] quota, bit req,
			logic [DOC_W-1:0] doc, logic [OWNER_W-1:0] owner, logic [PAGES_W-1:0] pages,
			logic [BUD_W-1:0] budget, logic [7:0] reps, bit fixed, status_t fst,
			logic [CNT_W-1:0] fcnt);
		stim_row_t r;
		r.set_q = set_q;
		r.quota = quota;
		r.req = req;
		r.doc = doc;
		r.owner = owner;
		r.pages = pages;
		r.budget = budget;
		r.reps = reps;
		r.fixed = fixed;
		r.fst = fst;
		r.fcnt = fcnt;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch on result %0d: %s is %0d, expected %0d", n_results, what, got,
				want);
	endtask

	// Applies one accepted word to the shadow queue and queues the result words
	// it must cause, in order.
	task automatic job_queue_step(input bit req, input logic [DOC_W-1:0] doc,
			input logic [OWNER_W-1:0] owner, input logic [PAGES_W-1:0] pages,
			input logic [BUD_W-1:0] budget);
		result_t          w;
		int               found;
		int               slot;
		int               popped;
		logic [BUD_W-1:0] left;
		w = '0;
		if (req == REQ_SUBMIT) begin
			// Count the owner's queued jobs, then check quota before fullness.
			found = 0;
			slot = q_head;
			for (int i = 0; i < q_fill; i++) begin
				if (q_owner[slot] == owner)
					found++;
				slot = (slot + 1) % DEPTH;
			end
			if (found >= q_quota) begin
				w.status = ST_QUOTA_REJ;
			end else if (q_fill >= DEPTH) begin
				w.status = ST_FULL_REJ;
			end else begin
				q_doc[q_tail] = doc;
				q_owner[q_tail] = owner;
				q_pages[q_tail] = pages;
				q_tail = (q_tail + 1) % DEPTH;
				q_fill++;
				w.status = ST_ACCEPTED;
			end
			w.doc = doc;
			w.owner = owner;
			w.pages = pages;
			w.left = '0;
			w.cnt = (found > CNT_MAX) ? CNT_MAX : CNT_W'(found);
			w.last = 1'b1;
			awaited_results.push_back(w);
		end else begin
			// Print from the head while the pages fit what is left of the budget, up to the pop limit.
			left = budget;
			popped = 0;
			while (q_fill > 0 && popped < DRAIN_POPS && left >= q_pages[q_head]) begin
				left = left - q_pages[q_head];
				w.status = ST_PRINTED;
				w.doc = q_doc[q_head];
				w.owner = q_owner[q_head];
				w.pages = q_pages[q_head];
				w.left = left;
				w.cnt = '0;
				w.last = 1'b0;
				awaited_results.push_back(w);
				q_head = (q_head + 1) % DEPTH;
				q_fill--;
				popped++;
			end
			w = '0;
			if (q_fill == 0) begin
				w.status = ST_ALL_DONE;
			end else begin
				w.status = ST_STOPPED;
				w.doc = q_doc[q_head];
				w.owner = q_owner[q_head];
				w.pages = q_pages[q_head];
			end
			w.left = left;
			w.last = 1'b1;
			awaited_results.push_back(w);
		end
	endtask

	// Offers one word after a random gap and waits until it is taken.
	task automatic offer_word(input bit req, input logic [DOC_W-1:0] doc,
			input logic [OWNER_W-1:0] owner, input logic [PAGES_W-1:0] pages,
			input logic [BUD_W-1:0] budget);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		doc_id <= doc;
		owner_id <= owner;
		page_count <= pages;
		paper_budget <= budget;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_words++;
		job_queue_step(req, doc, owner, pages, budget);
	endtask

	// Holds the sender back until every awaited result word has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes the quota register once the block has gone idle.
	task automatic set_quota(input logic [CNT_W-1:0] value);
		wait_for_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		q_quota = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (long_hold) begin
			long_hold = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare every taken result word with the oldest awaited one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected word, status", status, 0);
			end else begin
				want = awaited_results.pop_front();
				case (want.status)
					ST_PRINTED:   n_printed++;
					ST_QUOTA_REJ: n_quota_rej++;
					ST_FULL_REJ:  n_full_rej++;
					default:      ;
				endcase
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (out_doc !== want.doc)
					report_mismatch("out_doc", out_doc, want.doc);
				if (out_owner !== want.owner)
					report_mismatch("out_owner", out_owner, want.owner);
				if (out_pages !== want.pages)
					report_mismatch("out_pages", out_pages, want.pages);
				if (paper_left !== want.left)
					report_mismatch("paper_left", paper_left, want.left);
				if (owner_count !== want.cnt)
					report_mismatch("owner_count", owner_count, want.cnt);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	// Main sequence: reset, directed script, three random segments, drain out.
	initial begin
		stim_row_t          r;
		result_t            w;
		bit                 req;
		logic [DOC_W-1:0]   doc;
		logic [OWNER_W-1:0] owner;
		logic [PAGES_W-1:0] pages;
		logic [BUD_W-1:0]   budget;

		// Reset quota of three: empty drain, extremes, owner filling its quota.
		script.push_back(row(0, 0, REQ_DRAIN, 16'h0000, 8'h00, 12'h000, 16'h0000, 1, 1,
			ST_ALL_DONE, 0));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'hFFFF, 8'hFF, 12'hFFF, 16'hFFFF, 1, 1,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0000, 8'h00, 12'h000, 16'h0000, 1, 1,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0101, 8'hFF, 12'h005, 16'h0000, 1, 1,
			ST_ACCEPTED, 1));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0102, 8'hFF, 12'h005, 16'h0000, 1, 1,
			ST_ACCEPTED, 2));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0103, 8'hFF, 12'h005, 16'h0000, 1, 1,
			ST_QUOTA_REJ, 3));
		script.push_back(row(0, 0, REQ_DRAIN, 16'h0000, 8'h00, 12'h000, 16'h0000, 1, 0,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_DRAIN, 16'h0000, 8'h00, 12'h000, 16'hFFFE, 1, 0,
			ST_ACCEPTED, 0));
		// Quota of zero rejects everything.
		script.push_back(row(1, 0, REQ_SUBMIT, 16'h0200, 8'h12, 12'h00A, 16'h0000, 1, 1,
			ST_QUOTA_REJ, 0));
		// Quota of sixteen: one owner fills the queue; quota wins over full.
		script.push_back(row(1, 16, REQ_SUBMIT, 16'h0300, 8'h07, 12'h001, 16'h0000, 16, 0,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0400, 8'h07, 12'h001, 16'h0000, 1, 1,
			ST_QUOTA_REJ, 16));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0401, 8'h08, 12'h001, 16'h0000, 1, 1,
			ST_FULL_REJ, 0));
		// Quota above the depth: only the full check limits admission.
		script.push_back(row(1, 31, REQ_SUBMIT, 16'h0402, 8'h07, 12'h001, 16'h0000, 1, 1,
			ST_FULL_REJ, 16));
		script.push_back(row(0, 0, REQ_DRAIN, 16'h0000, 8'h00, 12'h000, 16'h0005, 1, 0,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_DRAIN, 16'h0000, 8'h00, 12'h000, 16'hFFFF, 1, 0,
			ST_ACCEPTED, 0));
		// Quota of one, and a budget that exactly matches the head job.
		script.push_back(row(1, 1, REQ_SUBMIT, 16'h0500, 8'h03, 12'h7FF, 16'h0000, 1, 1,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0501, 8'h03, 12'h800, 16'h0000, 1, 1,
			ST_QUOTA_REJ, 1));
		script.push_back(row(0, 0, REQ_SUBMIT, 16'h0502, 8'h04, 12'h800, 16'h0000, 1, 1,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_DRAIN, 16'h0000, 8'h00, 12'h000, 16'h07FF, 1, 0,
			ST_ACCEPTED, 0));
		script.push_back(row(0, 0, REQ_DRAIN, 16'h0000, 8'h00, 12'h000, 16'hFFFF, 1, 0,
			ST_ACCEPTED, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed script. Typed rows replace the predicted word.
		foreach (script[i]) begin
			r = script[i];
			if (r.set_q)
				set_quota(r.quota);
			for (int k = 0; k < r.reps; k++)
				offer_word(r.req, r.doc + DOC_W'(k), r.owner, r.pages, r.budget);
			if (r.fixed) begin
				void'(awaited_results.pop_back());
				w = '0;
				w.status = r.fst;
				w.cnt = r.fcnt;
				w.last = 1'b1;
				if (r.req == REQ_SUBMIT) begin
					w.doc = r.doc;
					w.owner = r.owner;
					w.pages = r.pages;
				end else begin
					w.left = r.budget;
				end
				awaited_results.push_back(w);
			end
		end

		// Random segments, each with its own quota and idling pattern.
		for (int seg = 0; seg < 3; seg++) begin
			case (seg)
				0: begin
					sender_idle_pct = 24;
					recv_idle_pct = 51;
				end
				1: begin
					sender_idle_pct = 51;
					recv_idle_pct = 24;
				end
				default: begin
					sender_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_quota(CNT_W'($urandom_range(1, 16)));
			for (int k = 0; k < 28; k++) begin
				if (seg == 0 && k == 10)
					long_hold = 1'b1;
				if (seg == 1 && k == 20)
					wait_for_results();
				// Few owners so quotas bite; mostly small page counts so drains print.
				req = ($urandom_range(99) < 35) ? REQ_DRAIN : REQ_SUBMIT;
				doc = DOC_W'($urandom);
				owner = ($urandom_range(3) == 0) ? OWNER_W'($urandom_range(255))
					: OWNER_W'($urandom_range(3));
				pages = ($urandom_range(4) == 0) ? PAGES_W'($urandom_range(4095))
					: PAGES_W'($urandom_range(64));
				case ($urandom_range(3))
					0: budget = '0;
					1: budget = BUD_W'($urandom_range(100));
					2: budget = BUD_W'($urandom_range(600));
					default: budget = BUD_W'($urandom_range(65535));
				endcase
				offer_word(req, doc, owner, pages, budget);
			end
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d words in and %0d result words out", n_words, n_results);
		$display("  %0d jobs printed, %0d quota rejects, %0d full rejects", n_printed,
			n_quota_rej, n_full_rej);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("tb_quota_fifo_with_budget_drain: clean");
		end else begin
			$display("tb_quota_fifo_with_budget_drain: errors");
		end
		$finish;
	end

endmodule
